// ===== hdl/svm_pkg.sv =====
`timescale 1ns / 1ps
package svm_pkg;
  localparam int VOICES_DEF        = 32;
  localparam int SMEM_FRAMES       = 65536;
  localparam int SOUND_IDS_DEF     = 8;
  localparam logic [15:0] UNITY    = 16'h8000;

  // cfg_ register map
  localparam logic [0:0] REG_MASTER_VOLUME = 1'b0;
  localparam logic [0:0] REG_MONO_OUTPUT   = 1'b1;

  typedef enum logic [2:0] {
    FN_RENDER  = 3'd0,
    FN_PLAY    = 3'd1,
    FN_LOOP    = 3'd2,
    FN_STOP    = 3'd3,
    FN_STOPALL = 3'd4,
    FN_SETVOL  = 3'd5,
    FN_QUERY   = 3'd6,
    FN_WRITE   = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_RD, ST_GAIN, ST_MUL, ST_ACC, ST_DONE
  } state_t;

  // Q1.15 saturation of a 16-bit gain
  function automatic logic [15:0] sat_gain(input logic [15:0] g);
    sat_gain = (g > UNITY) ? UNITY : g;
  endfunction
endpackage

// ===== hdl/svm_mac.sv =====
`timescale 1ns / 1ps
// Shared 18x18 signed multiplier with registered product.
module svm_mac import svm_pkg::*; (
  input  logic               clk,
  input  logic signed [17:0] a,
  input  logic signed [17:0] b,
  output logic signed [35:0] p_r
);
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end
endmodule

// ===== hdl/sample_voice_mixer.sv =====
`timescale 1ns / 1ps
// Sample voice mixer. Commands arrive as one transaction on the in_ stream and
// each yields exactly one result transaction on the out_ stream. The voice
// table is walked by a small sequencer that shares one multiplier. A render
// reads each sounding voice's sample, forms its gain, then multiplies and
// accumulates left and right in stereo mode (the summed sample in mono);
// idle or expiring voices are skipped. Play, stop, stop-all, set-volume and
// query walk the whole table; a sample write skips the walk.
// in_tready is high only when the sequencer is idle and no result is waiting.
// Sample memory has no reset; reading an unwritten frame returns unspecified
// data.
module sample_voice_mixer import svm_pkg::*; #(
  parameter int VOICES        = VOICES_DEF,
  parameter int SOUND_IDS     = SOUND_IDS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [15:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // func
  input  logic [2:0]   in_tuser,
  // in_left, in_right, sound tag, sound_base, sound_length, voice_gain,
  // handle, sample_addr, sample_left, sample_right (lowest first), 4 pad bits
  input  logic [183:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // mix_left, mix_right, handle_out, found (lowest first), 7 pad bits
  output logic [87:0]  out_tdata
);
  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int AW = $clog2(SMEM_FRAMES);

  // config
  logic [15:0] mvol_r;
  logic        mono_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mvol_r <= UNITY;
      mono_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == REG_MASTER_VOLUME)    mvol_r <= sat_gain(cfg_wdata);
      else if (cfg_index == REG_MONO_OUTPUT) mono_r <= cfg_wdata[0];
    end
  end

  // command fields, func in the low bits
  logic [182:0] cmd_r;
  logic [2:0]   c_func;
  logic signed [23:0] c_inl, c_inr;
  logic [2:0]   c_sid;
  logic [15:0]  c_base, c_gain, c_saddr, c_sl, c_sr;
  logic [16:0]  c_len;
  logic [31:0]  c_handle;
  assign c_func   = cmd_r[2:0];
  assign c_inl    = cmd_r[26:3];
  assign c_inr    = cmd_r[50:27];
  assign c_sid    = cmd_r[53:51];
  assign c_base   = cmd_r[69:54];
  assign c_len    = cmd_r[86:70];
  assign c_gain   = cmd_r[102:87];
  assign c_handle = cmd_r[134:103];
  assign c_saddr  = cmd_r[150:135];
  assign c_sl     = cmd_r[166:151];
  assign c_sr     = cmd_r[182:167];

  // voice table
  logic [VOICES-1:0] act_r, loop_r;
  logic [2:0]  vsnd_r [VOICES];
  logic [31:0] vhdl_r [VOICES];
  logic [15:0] vbase_r[VOICES];
  logic [16:0] vlen_r [VOICES];
  logic [16:0] vpos_r [VOICES];
  logic [15:0] vvol_r [VOICES];
  logic [31:0] nh_r;

  logic [31:0] smem [SMEM_FRAMES];
  logic [31:0] rd_r;

  state_t st_r, st_nxt;
  logic [VW:0] idx_r;
  logic [VW-1:0] vi;
  assign vi = idx_r[VW-1:0];

  logic signed [25:0] accl_r, accr_r;
  logic [15:0] g_r;
  logic        phase_r;       // multiplier pass: 0 left/mono, 1 right
  logic        hit_r, slot_ok_r, slot_idle_r;
  logic [VW-1:0] slot_r;
  logic        ov_r;
  logic [87:0] res_r;

  logic signed [17:0] ma, mb;
  logic signed [35:0] mp;
  svm_mac u_mac (.clk(clk), .a(ma), .b(mb), .p_r(mp));

  // First sample multiply of a voice takes the gain straight from the
  // product register (GAIN just wrote it); g_r keeps it for the right pass.
  logic [15:0] gain_sel;
  assign gain_sel = (st_r == ST_MUL && !phase_r) ? mp[30:15] : g_r;

  logic signed [16:0] sl, sr;
  assign sl = {{1{rd_r[15]}}, rd_r[15:0]};
  assign sr = {{1{rd_r[31]}}, rd_r[31:16]};

  always_comb begin
    ma = '0;
    mb = '0;
    if (st_r == ST_GAIN) begin
      ma = {2'b00, vvol_r[vi]};
      mb = {2'b00, mvol_r};
    end else if (mono_r) begin
      ma = {sl[16], sl} + {sr[16], sr};
      mb = {2'b00, gain_sel};
    end else begin
      ma = phase_r ? {sr[16], sr} : {sl[16], sl};
      mb = {2'b00, gain_sel};
    end
  end

  logic in_acc, out_acc;
  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign in_tready = (st_r == ST_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tdata = res_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (in_acc) st_nxt = ST_SCAN;
      ST_SCAN: begin
        if (c_func == FN_WRITE) st_nxt = ST_DONE;
        else if (c_func == FN_RENDER) begin
          if (idx_r == (VW+1)'(VOICES)) st_nxt = ST_DONE;
          else if (act_r[vi] && !(vpos_r[vi] >= vlen_r[vi] && !loop_r[vi]))
            st_nxt = ST_RD;
        end else if (idx_r == (VW+1)'(VOICES)) st_nxt = ST_DONE;
      end
      ST_RD:   st_nxt = ST_GAIN;
      ST_GAIN: st_nxt = ST_MUL;
      ST_MUL:  st_nxt = ST_ACC;
      ST_ACC:  st_nxt = (!mono_r && !phase_r) ? ST_MUL : ST_SCAN;
      ST_DONE: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else        st_r <= st_nxt;
  end

  // saturate 26-bit accumulator to 24 bits
  function automatic logic [23:0] sat24(input logic signed [25:0] x);
    if (x > 26'sd8388607)       sat24 = 24'h7FFFFF;
    else if (x < -26'sd8388608) sat24 = 24'h800000;
    else                        sat24 = x[23:0];
  endfunction

  logic id_ok;
  assign id_ok = (c_sid != 3'd0) && (32'(c_sid) < 32'(SOUND_IDS)) && (c_len != 17'd0);

  always_ff @(posedge clk) begin
    if (st_r == ST_SCAN && c_func == FN_WRITE)
      smem[c_saddr[AW-1:0]] <= {c_sr, c_sl};
    if (st_r == ST_RD)
      rd_r <= smem[AW'(vbase_r[vi] + 16'(vpos_r[vi]))];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= '0;
      loop_r <= '0;
      nh_r   <= 32'd1;
      ov_r   <= 1'b0;
      idx_r  <= '0;
    end else begin
      if (out_acc) ov_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: if (in_acc) begin
          cmd_r   <= {in_tdata[179:0], in_tuser};
          idx_r   <= '0;
          accl_r  <= 26'(signed'(in_tdata[23:0]));
          accr_r  <= 26'(signed'(in_tdata[47:24]));
          hit_r   <= 1'b0;
          slot_ok_r   <= 1'b0;
          slot_idle_r <= 1'b0;
          slot_r  <= '0;
        end
        ST_SCAN: if (idx_r != (VW+1)'(VOICES)) begin
          unique case (c_func)
            FN_RENDER: begin
              if (act_r[vi] && vpos_r[vi] >= vlen_r[vi]) begin
                if (loop_r[vi]) vpos_r[vi] <= '0;
                else act_r[vi] <= 1'b0;
              end
              if (!(act_r[vi] && !(vpos_r[vi] >= vlen_r[vi] && !loop_r[vi])))
                idx_r <= idx_r + 1'b1;
            end
            FN_PLAY, FN_LOOP: begin
              idx_r <= idx_r + 1'b1;
              if (!act_r[vi] && !slot_idle_r) begin
                slot_idle_r <= 1'b1; slot_ok_r <= 1'b1; slot_r <= vi;
              end else if (!loop_r[vi] && !slot_ok_r) begin
                slot_ok_r <= 1'b1; slot_r <= vi;
              end
            end
            FN_STOPALL: begin
              idx_r <= idx_r + 1'b1;
              if (act_r[vi] && vsnd_r[vi] == c_sid) begin
                act_r[vi] <= 1'b0; hit_r <= 1'b1;
              end
            end
            FN_STOP, FN_SETVOL, FN_QUERY: begin
              idx_r <= idx_r + 1'b1;
              if (!hit_r && c_handle != 32'd0 && act_r[vi] && vhdl_r[vi] == c_handle) begin
                hit_r <= 1'b1;
                if (c_func == FN_STOP)   act_r[vi]  <= 1'b0;
                if (c_func == FN_SETVOL) vvol_r[vi] <= sat_gain(c_gain);
              end
            end
            default: ;
          endcase
        end
        ST_RD:  phase_r <= 1'b0;
        ST_GAIN: ;
        ST_MUL: if (phase_r == 1'b0) g_r <= mp[30:15];
        ST_ACC: begin
          if (mono_r) accl_r <= accl_r + 26'(mp >>> 16);
          else if (!phase_r) accl_r <= accl_r + 26'(mp >>> 15);
          else accr_r <= accr_r + 26'(mp >>> 15);
          phase_r <= 1'b1;
          if (mono_r || phase_r) begin
            vpos_r[vi] <= vpos_r[vi] + 17'd1;
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_DONE: begin
          ov_r  <= 1'b1;
          unique case (c_func)
            FN_RENDER: begin
              res_r <= {8'd0, 32'd0, (mono_r ? c_inr : sat24(accr_r)), sat24(accl_r)};
            end
            FN_PLAY, FN_LOOP: begin
              if (id_ok && slot_ok_r) begin
                res_r           <= {8'd0, nh_r, 48'd0};
                act_r[slot_r]   <= 1'b1;
                loop_r[slot_r]  <= (c_func == FN_LOOP);
                vsnd_r[slot_r]  <= c_sid;
                vhdl_r[slot_r]  <= nh_r;
                vbase_r[slot_r] <= c_base;
                vlen_r[slot_r]  <= c_len;
                vpos_r[slot_r]  <= '0;
                vvol_r[slot_r]  <= sat_gain(c_gain);
                nh_r <= (nh_r == 32'hFFFFFFFF) ? 32'd1 : nh_r + 32'd1;
              end else begin
                res_r <= '0;
              end
            end
            FN_WRITE: res_r <= '0;
            default: res_r <= {7'd0, hit_r, 80'd0};
          endcase
        end
        default: ;
      endcase
    end
  end

  ap_nh_nonzero: assert property (@(posedge clk) disable iff (!rst_n) nh_r != 32'd0)
    else $error("next handle reached zero");
  ap_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> !in_tready) else $error("ready while busy");
  ap_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DONE) |=> out_tvalid) else $error("result lost");
endmodule
